@@ rtl/disk_block_allocator_assert.svh @@
// Assertion macros used by the allocator checker
`ifndef DISK_BLOCK_ALLOCATOR_ASSERT_SVH
`define DISK_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define DBA_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("disk block allocator check failed");

// next-cycle implication, clocked on clock, off during reset
`define DBA_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("disk block allocator check failed");

`endif

@@ rtl/dba_pkg.sv @@
// Types, constants and codes of the disk block allocator
package dba_pkg;

   localparam int STORE_BLOCKS = 256;
   localparam int MAX_FILES    = 16;
   localparam int ID_BITS      = 16;

   localparam int OPCODE_W   = 2;
   localparam int ID_FIELD_W = 16;
   localparam int SIZE_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int VALUE_W    = 9;
   localparam int CSR_W      = 9;

   localparam int BLK_IDX_W  = $clog2(STORE_BLOCKS);
   localparam int BLK_CNT_W  = $clog2(STORE_BLOCKS + 1);
   localparam int SLOT_W     = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int SLOT_CNT_W = $clog2(MAX_FILES + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_DEFRAG = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [ID_FIELD_W-1:0] file_id;
      logic [SIZE_W-1:0]     file_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       add_start;
      logic       add_step;
      logic       add_finish;
      logic       rem_start;
      logic       rem_read;
      logic       rem_eval;
      logic       rem_finish;
      logic       df_start;
      logic       df_find_step;
      logic       df_pick;
      logic       df_next;
      logic       df_place_step;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                too_big;
      logic                hit;
      logic                slot_avail;
      logic                add_done;
      logic                scan_end;
      logic                fs_end;
      logic                best_valid;
      logic                place_done;
      logic                rsp_free;
   } stat_type;

endpackage

@@ rtl/disk_block_allocator.sv @@
// Add: one block scanned per cycle.
// Remove: owner memory read then check per block.
// Defrag: file table scanned per pick.
// One item at a time; the result register frees the result side from the next item.
// Synchronous reset empties store and file table, 256 blocks managed, no clearing pass.
module disk_block_allocator import dba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   logic     idle;

   assign req_stall = !idle;
   assign csr_ready = idle;

   dba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle)
   );

   dba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/dba_ctrl.sv @@
// Operation sequencer of the disk block allocator
module dba_ctrl import dba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     idle
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DECODE   = 9'b000000010,
      S_ADD_SCAN = 9'b000000100,
      S_REM_RD   = 9'b000001000,
      S_REM_EV   = 9'b000010000,
      S_DF_FIND  = 9'b000100000,
      S_DF_PLACE = 9'b001000000,
      S_RESULT   = 9'b010000000,
      S_SPARE    = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   status_type st_ff, st_in;

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = '0;
      cmd.rsp_status = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            st_in    = ST_DONE;
            state_in = S_RESULT;
            case (stat.op)
               OP_ADD: begin
                  if (stat.too_big) begin
                     st_in = ST_NOSPACE;
                  end else if (stat.hit || stat.slot_avail) begin
                     cmd.add_start = 1'b1;
                     state_in      = S_ADD_SCAN;
                  end else begin
                     st_in = ST_FULL;
                  end
               end
               OP_REMOVE: begin
                  if (!stat.hit) begin
                     st_in = ST_NOSPACE;
                  end else begin
                     cmd.rem_start = 1'b1;
                     state_in      = S_REM_RD;
                  end
               end
               OP_DEFRAG: begin
                  cmd.df_start = 1'b1;
                  state_in     = S_DF_FIND;
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_ADD_SCAN: begin
            if (stat.add_done) begin
               cmd.add_finish = 1'b1;
               state_in       = S_RESULT;
            end else begin
               cmd.add_step = 1'b1;
            end
         end
         S_REM_RD: begin
            if (stat.scan_end) begin
               cmd.rem_finish = 1'b1;
               state_in       = S_RESULT;
            end else begin
               cmd.rem_read = 1'b1;
               state_in     = S_REM_EV;
            end
         end
         S_REM_EV: begin
            cmd.rem_eval = 1'b1;
            state_in     = S_REM_RD;
         end
         S_DF_FIND: begin
            if (!stat.fs_end) begin
               cmd.df_find_step = 1'b1;
            end else if (stat.best_valid) begin
               cmd.df_pick = 1'b1;
               state_in    = S_DF_PLACE;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_DF_PLACE: begin
            if (stat.place_done) begin
               cmd.df_next = 1'b1;
               state_in    = S_DF_FIND;
            end else begin
               cmd.df_place_step = 1'b1;
            end
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_DONE;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

@@ rtl/dba_datapath.sv @@
// Block bitmap, owner memory, file table and result register
module dba_datapath import dba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             rsp_stall,
   output stat_type         stat,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   logic [OPCODE_W-1:0]  op_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [SIZE_W-1:0]    size_ff;

   logic [STORE_BLOCKS-1:0] used_ff, used_in;
   logic [SLOT_W-1:0]       owner_mem [STORE_BLOCKS];
   logic [SLOT_W-1:0]       owner_rd_ff;

   logic [ID_BITS-1:0]   ident_ff [MAX_FILES];
   logic [ID_BITS-1:0]   ident_in [MAX_FILES];
   logic [BLK_CNT_W-1:0] count_ff [MAX_FILES];
   logic [BLK_CNT_W-1:0] count_in [MAX_FILES];
   logic [MAX_FILES-1:0] present_ff, present_in;
   logic [MAX_FILES-1:0] placed_ff, placed_in;

   logic [BLK_CNT_W-1:0] free_ff, free_in;
   logic [BLK_CNT_W-1:0] active_ff, active_in;
   logic [BLK_CNT_W-1:0] idx_ff, idx_in;
   logic [BLK_CNT_W-1:0] given_ff, given_in;
   logic [BLK_IDX_W-1:0] last_ff, last_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [BLK_CNT_W-1:0] pos_ff, pos_in;
   logic [BLK_CNT_W-1:0] pcnt_ff, pcnt_in;
   logic [SLOT_CNT_W-1:0] fs_ff, fs_in;
   logic [SLOT_W-1:0]    best_ff, best_in;
   logic                 bv_ff, bv_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 hit;
   logic [SLOT_W-1:0]    hit_idx;
   logic                 slot_avail;
   logic [SLOT_W-1:0]    free_idx;
   logic [SLOT_W-1:0]    fs_slot;
   logic [BLK_IDX_W-1:0] idx_blk;
   logic [BLK_IDX_W-1:0] pos_blk;
   logic                 own_we;
   logic [BLK_IDX_W-1:0] own_addr;
   logic [SLOT_W-1:0]    own_data;
   logic [BLK_CNT_W-1:0] clamp;
   logic [VALUE_W-1:0]   res_value;

   assign fs_slot = fs_ff[SLOT_W-1:0];
   assign idx_blk = idx_ff[BLK_IDX_W-1:0];
   assign pos_blk = pos_ff[BLK_IDX_W-1:0];

   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      slot_avail = 1'b0;
      free_idx   = '0;
      for (int s = MAX_FILES - 1; s >= 0; s--) begin
         if (present_ff[s] && ident_ff[s] == id_ff) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(s);
         end
         if (!present_ff[s]) begin
            slot_avail = 1'b1;
            free_idx   = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      if (csr_wdata == '0) begin
         clamp = BLK_CNT_W'(1);
      end else if (32'(csr_wdata) > STORE_BLOCKS) begin
         clamp = BLK_CNT_W'(STORE_BLOCKS);
      end else begin
         clamp = BLK_CNT_W'(csr_wdata);
      end
   end

   assign stat.op         = op_ff;
   assign stat.too_big    = 32'(size_ff) > 32'(free_ff);
   assign stat.hit        = hit;
   assign stat.slot_avail = slot_avail;
   assign stat.add_done   = (32'(given_ff) == 32'(size_ff)) || (idx_ff == active_ff);
   assign stat.scan_end   = (idx_ff == active_ff);
   assign stat.fs_end     = (32'(fs_ff) == MAX_FILES);
   assign stat.best_valid = bv_ff;
   assign stat.place_done = (pcnt_ff == count_ff[best_ff]) || (32'(pos_ff) == STORE_BLOCKS);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign own_we   = (cmd.add_step && !used_ff[idx_blk]) || cmd.df_place_step;
   assign own_addr = cmd.add_step ? idx_blk : pos_blk;
   assign own_data = cmd.add_step ? slot_ff : best_ff;

   always_comb begin
      res_value = '0;
      if (cmd.rsp_status == ST_DONE) begin
         case (op_ff)
            OP_ADD:    res_value = VALUE_W'(last_ff);
            OP_REMOVE: res_value = VALUE_W'(free_ff);
            OP_DEFRAG: res_value = VALUE_W'(pos_ff);
            default:   res_value = '0;
         endcase
      end
   end

   always_comb begin
      used_in    = used_ff;
      ident_in   = ident_ff;
      count_in   = count_ff;
      present_in = present_ff;
      placed_in  = placed_ff;
      free_in    = free_ff;
      active_in  = active_ff;
      idx_in     = idx_ff;
      given_in   = given_ff;
      last_in    = last_ff;
      slot_in    = slot_ff;
      pos_in     = pos_ff;
      pcnt_in    = pcnt_ff;
      fs_in      = fs_ff;
      best_in    = best_ff;
      bv_in      = bv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         active_in  = clamp;
         free_in    = clamp;
         used_in    = '0;
         present_in = '0;
         for (int s = 0; s < MAX_FILES; s++) begin
            count_in[s] = '0;
         end
      end else begin
         if (cmd.add_start) begin
            idx_in   = '0;
            given_in = '0;
            last_in  = '0;
            slot_in  = hit ? hit_idx : free_idx;
            if (!hit) begin
               present_in[free_idx] = 1'b1;
               ident_in[free_idx]   = id_ff;
               count_in[free_idx]   = '0;
            end
         end
         if (cmd.add_step) begin
            if (!used_ff[idx_blk]) begin
               used_in[idx_blk] = 1'b1;
               given_in         = given_ff + 1'b1;
               last_in          = idx_blk;
            end
            idx_in = idx_ff + 1'b1;
         end
         if (cmd.add_finish) begin
            count_in[slot_ff] = count_ff[slot_ff] + given_ff;
            free_in           = free_ff - given_ff;
         end
         if (cmd.rem_start) begin
            idx_in  = '0;
            slot_in = hit_idx;
         end
         if (cmd.rem_eval) begin
            if (used_ff[idx_blk] && owner_rd_ff == slot_ff) begin
               used_in[idx_blk] = 1'b0;
               free_in          = free_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         if (cmd.rem_finish) begin
            present_in[slot_ff] = 1'b0;
            count_in[slot_ff]   = '0;
         end
         if (cmd.df_start) begin
            used_in   = '0;
            placed_in = '0;
            pos_in    = '0;
            fs_in     = '0;
            bv_in     = 1'b0;
         end
         if (cmd.df_find_step) begin
            if (present_ff[fs_slot] && !placed_ff[fs_slot] &&
                (!bv_ff || ident_ff[fs_slot] < ident_ff[best_ff])) begin
               best_in = fs_slot;
               bv_in   = 1'b1;
            end
            fs_in = fs_ff + 1'b1;
         end
         if (cmd.df_pick) begin
            placed_in[best_ff] = 1'b1;
            pcnt_in            = '0;
         end
         if (cmd.df_place_step) begin
            used_in[pos_blk] = 1'b1;
            pos_in           = pos_ff + 1'b1;
            pcnt_in          = pcnt_ff + 1'b1;
         end
         if (cmd.df_next) begin
            fs_in = '0;
            bv_in = 1'b0;
         end
      end

      if (cmd.rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.status = cmd.rsp_status;
         rsp_data_in.value  = res_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         present_ff   <= '0;
         placed_ff    <= '0;
         free_ff      <= BLK_CNT_W'(STORE_BLOCKS);
         active_ff    <= BLK_CNT_W'(STORE_BLOCKS);
         bv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_FILES; s++) begin
            count_ff[s] <= '0;
         end
      end else begin
         used_ff      <= used_in;
         present_ff   <= present_in;
         placed_ff    <= placed_in;
         free_ff      <= free_in;
         active_ff    <= active_in;
         bv_ff        <= bv_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_data.opcode;
         id_ff   <= req_data.file_id[ID_BITS-1:0];
         size_ff <= req_data.file_size;
      end
      ident_ff    <= ident_in;
      idx_ff      <= idx_in;
      given_ff    <= given_in;
      last_ff     <= last_in;
      slot_ff     <= slot_in;
      pos_ff      <= pos_in;
      pcnt_ff     <= pcnt_in;
      fs_ff       <= fs_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[own_addr] <= own_data;
      end
      if (cmd.rem_read) begin
         owner_rd_ff <= owner_mem[idx_blk];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/dba_checker.sv @@
// Port checker of the disk block allocator and its bind
`include "disk_block_allocator_assert.svh"
module dba_checker import dba_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `DBA_ASSERT_IMP(a_fail_zero, rsp_valid && rsp_data.status != ST_DONE, rsp_data.value == '0)
   `DBA_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `DBA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind disk_block_allocator dba_checker u_dba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ bench/disk_block_allocator_tb.sv @@
// Self-checking bench for the disk block allocator: random file traffic against a predictor
module disk_block_allocator_tb;
   import dba_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 2500;
   localparam int DRAIN_CYCLES   = 700;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_wdata = '0;

   req_type pending_words[$];
   rsp_type expected_words[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;
   bit      long_hold_req = 1'b0;
   bit      req_taken = 1'b0;
   int      send_gap = 0;
   int      hold_left = 0;

   // allocator state as predicted
   bit                    blk_used[STORE_BLOCKS];
   logic [SLOT_W-1:0]     blk_slot[STORE_BLOCKS];
   logic [ID_FIELD_W-1:0] f_ident[MAX_FILES];
   bit                    f_live[MAX_FILES];
   int unsigned           f_count[MAX_FILES];
   int unsigned           n_active;
   int unsigned           n_free;

   logic [ID_FIELD_W-1:0] id_pool[20];

   disk_block_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void empty_store(input logic [CSR_W-1:0] blocks);
      int unsigned n;
      n = blocks;
      if (n < 1) n = 1;
      if (n > STORE_BLOCKS) n = STORE_BLOCKS;
      n_active = n;
      n_free = n;
      for (int i = 0; i < STORE_BLOCKS; i++) begin
         blk_used[i] = 1'b0;
         blk_slot[i] = '0;
      end
      for (int s = 0; s < MAX_FILES; s++) begin
         f_ident[s] = '0;
         f_live[s] = 1'b0;
         f_count[s] = 0;
      end
   endfunction

   function automatic int slot_of(input logic [ID_FIELD_W-1:0] id);
      for (int s = 0; s < MAX_FILES; s++)
         if (f_live[s] && f_ident[s] == id) return s;
      return -1;
   endfunction

   function automatic rsp_type allocate(input req_type r);
      rsp_type     res;
      int          slot;
      int unsigned given;
      int unsigned last;
      bit          placed[MAX_FILES];
      int          best;
      int unsigned pos;
      res = '0;
      res.status = ST_DONE;
      case (r.opcode)
         OP_ADD: begin
            if (r.file_size > n_free) begin
               res.status = ST_NOSPACE;
               return res;
            end
            slot = slot_of(r.file_id);
            if (slot < 0) begin
               for (int s = 0; s < MAX_FILES; s++)
                  if (!f_live[s]) begin
                     slot = s;
                     break;
                  end
               if (slot < 0) begin
                  res.status = ST_FULL;
                  return res;
               end
               f_live[slot] = 1'b1;
               f_ident[slot] = r.file_id;
               f_count[slot] = 0;
            end
            given = 0;
            last = 0;
            for (int i = 0; i < n_active && given < r.file_size; i++)
               if (!blk_used[i]) begin
                  blk_used[i] = 1'b1;
                  blk_slot[i] = SLOT_W'(slot);
                  given++;
                  last = i;
               end
            n_free -= given;
            f_count[slot] += given;
            res.value = VALUE_W'(last);
         end
         OP_REMOVE: begin
            slot = slot_of(r.file_id);
            if (slot < 0) begin
               res.status = ST_NOSPACE;
               return res;
            end
            for (int i = 0; i < n_active; i++)
               if (blk_used[i] && blk_slot[i] == slot) begin
                  blk_used[i] = 1'b0;
                  n_free++;
               end
            f_live[slot] = 1'b0;
            f_count[slot] = 0;
            res.value = VALUE_W'(n_free);
         end
         OP_DEFRAG: begin
            pos = 0;
            for (int s = 0; s < MAX_FILES; s++) placed[s] = 1'b0;
            for (int i = 0; i < STORE_BLOCKS; i++) blk_used[i] = 1'b0;
            for (int k = 0; k < MAX_FILES; k++) begin
               best = -1;
               for (int s = 0; s < MAX_FILES; s++)
                  if (f_live[s] && !placed[s] && (best < 0 || f_ident[s] < f_ident[best]))
                     best = s;
               if (best < 0) break;
               placed[best] = 1'b1;
               for (int i = 0; i < f_count[best] && pos < STORE_BLOCKS; i++) begin
                  blk_used[pos] = 1'b1;
                  blk_slot[pos] = SLOT_W'(best);
                  pos++;
               end
            end
            res.value = VALUE_W'(pos);
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type make_word(input logic [OPCODE_W-1:0] op,
                                         input logic [ID_FIELD_W-1:0] id,
                                         input logic [SIZE_W-1:0] size);
      req_type r;
      r.opcode = op;
      r.file_id = id;
      r.file_size = size;
      return r;
   endfunction

   function automatic void queue_word(input req_type r);
      pending_words = {pending_words, r};
   endfunction

   function automatic req_type random_word();
      int unsigned pick;
      logic [SIZE_W-1:0] size;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         return make_word(OP_NONE, ID_FIELD_W'($urandom), SIZE_W'($urandom));
      if (pick < 8)
         return make_word(OPCODE_W'($urandom), ID_FIELD_W'($urandom), SIZE_W'($urandom));
      if (pick < 15)
         return make_word(OP_DEFRAG, id_pool[$urandom_range(0, 19)], SIZE_W'($urandom));
      if (pick < 45)
         return make_word(OP_REMOVE, id_pool[$urandom_range(0, 19)], SIZE_W'($urandom));
      case ($urandom_range(0, 9))
         0:       size = SIZE_W'($urandom);
         1:       size = '0;
         2:       size = SIZE_W'($urandom_range(60, 260));
         default: size = SIZE_W'($urandom_range(1, 24));
      endcase
      return make_word(OP_ADD, id_pool[$urandom_range(0, 19)], size);
   endfunction

   // sender: hold until taken, advance otherwise
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         req_data <= pending_words.pop_front();
         req_valid <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 9);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random stall bursts plus one long hold-off
   always @(negedge clock) begin
      if (long_hold_req && hold_left == 0) begin
         hold_left <= LONG_HOLD;
         long_hold_req <= 1'b0;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         hold_left <= $urandom_range(1, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
         if (req_valid && !req_stall) expected_words = {expected_words, allocate(req_data)};
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: status %0d value %0d",
                      got.status, got.value);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, got.value);
                  errors++;
               end
            end
         end
      end
   end

   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() > 0 || expected_words.size() > 0 || req_valid);
   endtask

   task automatic write_blocks(input logic [CSR_W-1:0] blocks);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= blocks;
      do @(posedge clock);
      while (!csr_ready);
      empty_store(blocks);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CSR_W-1:0] settings[6];
      int               per_phase;
      empty_store(CSR_W'(STORE_BLOCKS));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 20; i++) id_pool[i] = ID_FIELD_W'($urandom);
      id_pool[0] = '0;
      id_pool[1] = '1;

      // boundaries, every operation, zero-size add, full table, unknown file
      queue_word(make_word(OP_DEFRAG, 16'h0000, 10'h000));
      queue_word(make_word(OP_ADD, 16'h0000, 10'h000));
      queue_word(make_word(OP_ADD, 16'hFFFF, 10'h3FF));
      queue_word(make_word(OP_ADD, 16'hFFFF, 10'd256));
      queue_word(make_word(OP_ADD, 16'h1234, 10'd1));
      queue_word(make_word(OP_REMOVE, 16'hFFFF, 10'h3FF));
      queue_word(make_word(OP_REMOVE, 16'hAAAA, 10'h000));
      queue_word(make_word(OP_NONE, 16'h5555, 10'h2AA));
      for (int i = 1; i <= 16; i++)
         queue_word(make_word(OP_ADD, 16'(17 - i) * 16'h0F0F, 10'(i % 3)));
      queue_word(make_word(OP_DEFRAG, 16'hFFFF, 10'h3FF));
      drain();

      settings = '{9'd256, 9'd511, 9'd1, 9'd0, 9'd37, 9'd256};
      per_phase = 112;
      for (int p = 0; p < 6; p++) begin
         write_blocks(p == 0 ? 9'($urandom_range(2, 255)) : settings[p]);
         if (p == 5) quiet = 1'b1;
         if (p == 2) long_hold_req = 1'b1;
         for (int i = 0; i < per_phase; i++) queue_word(random_word());
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dba_pkg.sv
rtl/dba_ctrl.sv
rtl/dba_datapath.sv
rtl/disk_block_allocator.sv
rtl/dba_checker.sv
bench/disk_block_allocator_tb.sv
